>>> rtl/ssd_pkg.sv
// Shared constants and types for the sign sketch dot score unit.
package ssd_pkg;

  localparam int PROJECTION_SIZE = 256;
  localparam int CHUNK_BITS      = 64;
  localparam int QUERY_WIDTH     = 16;
  localparam int LANES           = 4;
  localparam int LANE_W          = 2;
  localparam int STEPS           = CHUNK_BITS / LANES;
  localparam int STEP_W          = 4;
  localparam int ACC_W           = 25;
  localparam int INDEX_W         = 8;
  localparam int CHUNK_W         = 2;
  localparam int SCALE_W         = 16;
  localparam int NORM_W          = 16;
  localparam int SCORE_W         = 32;
  localparam int P1_W            = ACC_W + SCALE_W;
  localparam int MAG_W           = P1_W + 8;
  localparam int PAD_W           = 33;
  localparam int Z_W             = MAG_W + PAD_W;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd321;
  localparam logic [7:0]         EXP_ZERO    = 8'd0;
  localparam logic [7:0]         EXP_MAX     = 8'd255;
  // exponent at which the padded product needs no shift (146 + PAD_W)
  localparam logic [7:0]         EXP_ALIGN   = 8'd179;
  localparam logic [SCORE_W-1:0] SCORE_MAX   = 32'h7FFF_FFFF;
  localparam logic [SCORE_W-1:0] SCORE_MIN   = 32'h8000_0000;

  localparam logic MODE_QUERY = 1'b0;
  localparam logic MODE_KEY   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_DRAIN,
    ST_MUL1,
    ST_MUL2,
    ST_SHIFT,
    ST_FINISH
  } state_t;

endpackage

>>> rtl/ssd_in_if.sv
// Input channel: query loads and key sign chunks.
interface ssd_in_if;
  logic                              valid;
  logic                              ready;
  logic                              mode;
  logic [ssd_pkg::INDEX_W-1:0]       query_index;
  logic signed [ssd_pkg::QUERY_WIDTH-1:0] query_value;
  logic [ssd_pkg::CHUNK_W-1:0]       chunk_index;
  logic [ssd_pkg::CHUNK_BITS-1:0]    sign_word;
  logic [ssd_pkg::NORM_W-1:0]        norm_bits;

  modport source (output valid, mode, query_index, query_value, chunk_index, sign_word,
                  norm_bits, input ready);
  modport sink   (input valid, mode, query_index, query_value, chunk_index, sign_word,
                  norm_bits, output ready);
endinterface

>>> rtl/ssd_out_if.sv
// Result channel: one score per key.
interface ssd_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ssd_pkg::SCORE_W-1:0] score;
  logic                               saturated;

  modport source (output valid, score, saturated, input ready);
  modport sink   (input valid, score, saturated, output ready);
endinterface

>>> rtl/sign_sketch_dot_score_unit.sv
// Top level: query store banks, shared accumulate unit and score scaling sequencer.
//
//   channel | dir | transfer when          | payload
//   in_ch   | in  | valid & ready          | mode, query_index, query_value, chunk_index,
//           |     |                        | sign_word, norm_bits
//   out_ch  | out | valid & ready          | score, saturated
//   cfg     | in  | cfg_we                 | cfg_wdata (score_scale)
//
// A query load is written to its bank on acceptance. A key chunk passes through accept, 16 accumulate steps of
// four query elements each from the banked store, and a drain state for the read pipeline.
// After the last chunk come two multiplies, shift and round/clamp before the score
// goes to the output register. rst_n is synchronous, active low; the query store is not
// cleared and must be loaded. A waiting score holds the output register; the block stalls
// only if a second score finishes before the first is taken.
module sign_sketch_dot_score_unit #(
  parameter int PROJECTION_SIZE = ssd_pkg::PROJECTION_SIZE
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ssd_in_if.sink                      in_ch,
  ssd_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [ssd_pkg::SCALE_W-1:0] cfg_wdata
);

  localparam int ROWS       = PROJECTION_SIZE / ssd_pkg::LANES;
  localparam int ABW        = $clog2(ROWS);
  localparam int LAST_CHUNK = PROJECTION_SIZE / ssd_pkg::CHUNK_BITS - 1;
  localparam int ROW_W      = ssd_pkg::CHUNK_W + ssd_pkg::STEP_W;

  ssd_pkg::state_t state_r, state_nxt;

  logic [ssd_pkg::SCALE_W-1:0]    scale_r;
  logic [ssd_pkg::CHUNK_W-1:0]    chunk_r;
  logic [ssd_pkg::CHUNK_BITS-1:0] sign_r;
  logic [ssd_pkg::NORM_W-1:0]     norm_r;
  logic [ssd_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic                           acc_en_r, rd_ok_r;
  logic signed [ssd_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [ssd_pkg::P1_W-1:0]       p1_r;
  logic [ssd_pkg::MAG_W-1:0]      mag_r;
  logic [ssd_pkg::Z_W-1:0]        qfull_r;
  logic                           sticky_r, big_r, mag_nz_r;
  logic                           out_valid_r, out_valid_nxt;
  logic signed [ssd_pkg::SCORE_W-1:0] score_r, score_nxt;
  logic                           sat_r, sat_nxt;

  // sequencer outputs
  logic in_ready, issue, load_out;

  logic accept, q_write, key_accept;
  assign accept     = in_ch.valid && in_ch.ready;
  assign q_write    = accept && (in_ch.mode == ssd_pkg::MODE_QUERY) &&
                      (32'(in_ch.query_index) < PROJECTION_SIZE);
  assign key_accept = accept && (in_ch.mode == ssd_pkg::MODE_KEY);

  // ---------------- query store: four banks, lane = element index mod 4
  logic [15:0]    wr_row16, rd_row16;
  logic [ABW-1:0] wr_addr, rd_addr;
  logic [ROW_W-1:0] rd_row;
  logic           rd_ok;
  logic [ssd_pkg::LANE_W-1:0] wr_lane;
  logic signed [ssd_pkg::QUERY_WIDTH-1:0] rd_q [ssd_pkg::LANES];

  assign wr_row16 = 16'(in_ch.query_index[ssd_pkg::INDEX_W-1:ssd_pkg::LANE_W]);
  assign wr_addr  = wr_row16[ABW-1:0];
  assign wr_lane  = in_ch.query_index[ssd_pkg::LANE_W-1:0];
  assign rd_row   = {chunk_r, step_r};
  assign rd_row16 = 16'(rd_row);
  assign rd_addr  = rd_row16[ABW-1:0];
  assign rd_ok    = 32'(rd_row) < ROWS;

  for (genvar l = 0; l < ssd_pkg::LANES; l++) begin : g_bank
    logic signed [ssd_pkg::QUERY_WIDTH-1:0] mem [ROWS];
    always_ff @(posedge clk) begin
      if (q_write && (wr_lane == ssd_pkg::LANE_W'(l))) begin
        mem[wr_addr] <= in_ch.query_value;
      end
      rd_q[l] <= mem[rd_addr];
    end
  end

  // ---------------- shared accumulate unit: four signed terms per step
  always_comb begin
    logic signed [ssd_pkg::ACC_W-1:0] sum;
    logic signed [ssd_pkg::ACC_W-1:0] term;
    sum = acc_r;
    for (int l = 0; l < ssd_pkg::LANES; l++) begin
      term = ssd_pkg::ACC_W'(rd_q[l]);
      sum  = sign_r[l] ? (sum + term) : (sum - term);
    end
    acc_nxt = acc_r;
    if (load_out) begin
      acc_nxt = '0;
    end else if (acc_en_r && rd_ok_r) begin
      acc_nxt = sum;
    end
  end

  // ---------------- sequencer: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ssd_pkg::ST_IDLE:   if (key_accept) state_nxt = ssd_pkg::ST_ACCUM;
      ssd_pkg::ST_ACCUM:  if (step_r == ssd_pkg::STEP_W'(ssd_pkg::STEPS - 1))
                            state_nxt = ssd_pkg::ST_DRAIN;
      ssd_pkg::ST_DRAIN:  state_nxt = (32'(chunk_r) == LAST_CHUNK) ? ssd_pkg::ST_MUL1
                                                                   : ssd_pkg::ST_IDLE;
      ssd_pkg::ST_MUL1:   state_nxt = ssd_pkg::ST_MUL2;
      ssd_pkg::ST_MUL2:   state_nxt = ssd_pkg::ST_SHIFT;
      ssd_pkg::ST_SHIFT:  state_nxt = ssd_pkg::ST_FINISH;
      ssd_pkg::ST_FINISH: if (load_out) state_nxt = ssd_pkg::ST_IDLE;
      default:            state_nxt = ssd_pkg::ST_IDLE;
    endcase
  end

  // ---------------- sequencer: outputs
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      ssd_pkg::ST_IDLE:   in_ready = 1'b1;
      ssd_pkg::ST_ACCUM:  issue    = 1'b1;
      ssd_pkg::ST_FINISH: load_out = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  assign step_nxt = issue ? ssd_pkg::STEP_W'(step_r + 1'b1) : '0;

  // ---------------- score arithmetic
  logic [ssd_pkg::ACC_W-1:0] abs_dot;
  logic [7:0]                mant, expo, shamt;
  logic                      neg;
  logic [ssd_pkg::Z_W-1:0]   z_w, msk;

  assign abs_dot = acc_r[ssd_pkg::ACC_W-1] ? ssd_pkg::ACC_W'(-acc_r)
                                          : ssd_pkg::ACC_W'(acc_r);
  assign mant    = {1'b1, norm_r[6:0]};
  assign expo    = norm_r[14:7];
  assign neg     = acc_r[ssd_pkg::ACC_W-1] ^ norm_r[15];
  assign z_w     = {mag_r, {ssd_pkg::PAD_W{1'b0}}};
  assign shamt   = ssd_pkg::EXP_ALIGN - expo;
  assign msk     = ~({ssd_pkg::Z_W{1'b1}} << shamt);

  always_comb begin
    logic [33:0] q_inc;
    q_inc     = {1'b0, qfull_r[32:0]} + 34'(neg && sticky_r);
    score_nxt = '0;
    sat_nxt   = 1'b0;
    priority if (expo == ssd_pkg::EXP_ZERO) begin
      sat_nxt = 1'b0;
    end else if (expo == ssd_pkg::EXP_MAX) begin
      sat_nxt = 1'b1;
    end else if (big_r) begin
      sat_nxt = mag_nz_r;
    end else if (|qfull_r[ssd_pkg::Z_W-1:33]) begin
      sat_nxt = 1'b1;
    end else if (!neg && (q_inc > 34'(ssd_pkg::SCORE_MAX))) begin
      sat_nxt = 1'b1;
    end else if (neg && (q_inc > 34'(ssd_pkg::SCORE_MIN))) begin
      sat_nxt = 1'b1;
    end else begin
      score_nxt = neg ? ssd_pkg::SCORE_W'(34'd0 - q_inc) : ssd_pkg::SCORE_W'(q_inc);
    end
    if (sat_nxt) begin
      score_nxt = neg ? ssd_pkg::SCORE_MIN : ssd_pkg::SCORE_MAX;
    end
  end

  assign out_valid_nxt = load_out ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  // ---------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssd_pkg::ST_IDLE;
      scale_r     <= ssd_pkg::SCALE_RESET;
      step_r      <= '0;
      acc_en_r    <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      acc_en_r    <= issue;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        scale_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_ok_r <= rd_ok;
    if (key_accept) begin
      chunk_r <= in_ch.chunk_index;
      sign_r  <= in_ch.sign_word;
      norm_r  <= in_ch.norm_bits;
    end else if (acc_en_r) begin
      // advance to the next group of lane signs
      sign_r <= sign_r >> ssd_pkg::LANES;
    end
    if (state_r == ssd_pkg::ST_MUL1) begin
      p1_r <= ssd_pkg::P1_W'(abs_dot) * ssd_pkg::P1_W'(scale_r);
    end
    if (state_r == ssd_pkg::ST_MUL2) begin
      mag_r <= ssd_pkg::MAG_W'(p1_r) * ssd_pkg::MAG_W'(mant);
    end
    if (state_r == ssd_pkg::ST_SHIFT) begin
      qfull_r  <= z_w >> shamt;
      sticky_r <= |(z_w & msk);
      big_r    <= expo > ssd_pkg::EXP_ALIGN;
      mag_nz_r <= |mag_r;
    end
    if (load_out) begin
      score_r <= score_nxt;
      sat_r   <= sat_nxt;
    end
  end

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.score     = score_r;
  assign out_ch.saturated = sat_r;

  // ---------------- assertions
  a_key_busy: assert property (@(posedge clk) disable iff (!rst_n)
    key_accept |=> !in_ch.ready)
    else $error("input still ready after a key chunk transfer");

  a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ssd_pkg::ST_ACCUM) |-> (step_r == '0))
    else $error("step counter running outside accumulation");

  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (acc_r == '0))
    else $error("accumulator not cleared after a score");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && sat_r) |-> (score_r == ssd_pkg::SCORE_MAX ||
                                score_r == ssd_pkg::SCORE_MIN))
    else $error("saturated score is not at a range limit");

endmodule

>>> tb/sign_sketch_dot_score_unit_tb.sv
// Self-checking testbench for the sign sketch dot score unit: query loads, key chunks, scores.
`timescale 1ns / 100ps

module sign_sketch_dot_score_unit_tb;
  import ssd_pkg::*;

  localparam int LAST_CHUNK     = PROJECTION_SIZE / CHUNK_BITS - 1;
  localparam int SCORE_EXP_BIAS = 146;
  localparam int QUIET_CYCLES   = 40;
  localparam int PHASE_ITEMS    = 234;
  localparam int MAX_REPORTS    = 10;
  localparam int IDLE_PCT       = 26;

  typedef struct packed {
    logic                          mode;
    logic [INDEX_W-1:0]            query_index;
    logic signed [QUERY_WIDTH-1:0] query_value;
    logic [CHUNK_W-1:0]            chunk_index;
    logic [CHUNK_BITS-1:0]         sign_word;
    logic [NORM_W-1:0]             norm_bits;
  } sketch_item_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      saturated;
  } score_t;

  // Tracks the query sketch, the running dot sum and the pending scores.
  class score_board;
    logic signed [QUERY_WIDTH-1:0] query_copy[PROJECTION_SIZE];
    logic signed [ACC_W-1:0]       dot_sum;
    logic [SCALE_W-1:0]            scale;
    score_t                        expected_scores[$];
    int                            mismatches;

    function new();
      foreach (query_copy[i]) query_copy[i] = '0;
      dot_sum    = '0;
      scale      = SCALE_RESET;
      mismatches = 0;
    endfunction

    function void set_scale(logic [SCALE_W-1:0] v);
      scale = v;
    endfunction

    function score_t scaled_score(logic signed [ACC_W-1:0] dot, logic [NORM_W-1:0] norm);
      logic [7:0]       ex;
      logic [ACC_W-1:0] abs_dot;
      logic [63:0]      mag;
      logic [63:0]      q;
      logic [63:0]      rem;
      logic             neg;
      logic             sat;
      int               k;
      int               r;
      score_t           res;
      ex  = norm[14:7];
      neg = dot[ACC_W-1] ^ norm[15];
      if (ex == EXP_ZERO) begin
        res.score     = '0;
        res.saturated = 1'b0;
        return res;
      end
      if (ex == EXP_MAX) begin
        res.score     = neg ? SCORE_MIN : SCORE_MAX;
        res.saturated = 1'b1;
        return res;
      end
      abs_dot = dot[ACC_W-1] ? -dot : dot;
      mag = 64'(abs_dot) * 64'(scale) * 64'({1'b1, norm[6:0]});
      sat = 1'b0;
      q   = '0;
      if (ex >= SCORE_EXP_BIAS) begin
        k = int'(ex) - SCORE_EXP_BIAS;
        if (mag == 0) q = '0;
        else if (k > 31 || mag >= (64'd1 << (62 - k))) sat = 1'b1;
        else q = mag << k;
      end else begin
        r = SCORE_EXP_BIAS - int'(ex);
        if (r >= 63) begin
          q   = '0;
          rem = mag;
        end else begin
          q   = mag >> r;
          rem = mag & ((64'd1 << r) - 1);
        end
        // round toward minus infinity on the signed value
        if (neg && rem != 0) q = q + 1;
      end
      if (!sat && ((!neg && q > 64'h7FFF_FFFF) || (neg && q > 64'h8000_0000))) sat = 1'b1;
      if (sat) begin
        res.score     = neg ? SCORE_MIN : SCORE_MAX;
        res.saturated = 1'b1;
      end else begin
        res.score     = neg ? -q[SCORE_W-1:0] : q[SCORE_W-1:0];
        res.saturated = 1'b0;
      end
      return res;
    endfunction

    function void note_item(sketch_item_t it);
      logic signed [QUERY_WIDTH-1:0] qv;
      if (it.mode == MODE_QUERY) begin
        query_copy[it.query_index] = it.query_value;
        return;
      end
      for (int i = 0; i < CHUNK_BITS; i++) begin
        qv = query_copy[int'(it.chunk_index) * CHUNK_BITS + i];
        if (it.sign_word[i]) dot_sum = dot_sum + {{(ACC_W-QUERY_WIDTH){qv[QUERY_WIDTH-1]}}, qv};
        else dot_sum = dot_sum - {{(ACC_W-QUERY_WIDTH){qv[QUERY_WIDTH-1]}}, qv};
      end
      if (it.chunk_index != LAST_CHUNK) return;
      expected_scores.push_back(scaled_score(dot_sum, it.norm_bits));
      dot_sum = '0;
    endfunction

    function void note_mismatch(string msg);
      if (mismatches < MAX_REPORTS) $display("%t %s", $realtime, msg);
      mismatches++;
    endfunction

    function void check_score(score_t got);
      score_t want;
      if (expected_scores.size() == 0) begin
        note_mismatch($sformatf("unexpected score %0d saturated %0b", got.score, got.saturated));
        return;
      end
      want = expected_scores.pop_front();
      if (got.score !== want.score || got.saturated !== want.saturated)
        note_mismatch($sformatf("score expected %0d saturated %0b, got %0d saturated %0b",
                                want.score, want.saturated, got.score, got.saturated));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [SCALE_W-1:0] cfg_wdata;
  bit                 calm;
  score_board         scores;

  ssd_in_if  in_ch ();
  ssd_out_if out_ch ();

  sign_sketch_dot_score_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Result side: check each transfer, stall at random.
  always @(posedge clk) begin
    score_t got;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.score     = out_ch.score;
        got.saturated = out_ch.saturated;
        scores.check_score(got);
      end
      out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  function automatic sketch_item_t random_fields();
    sketch_item_t it;
    it.mode        = 1'($urandom);
    it.query_index = INDEX_W'($urandom);
    it.query_value = QUERY_WIDTH'($urandom);
    it.chunk_index = CHUNK_W'($urandom);
    it.sign_word   = {$urandom, $urandom};
    it.norm_bits   = NORM_W'($urandom);
    return it;
  endfunction

  function automatic sketch_item_t query_item(int idx, logic [QUERY_WIDTH-1:0] val);
    sketch_item_t it;
    it             = random_fields();
    it.mode        = MODE_QUERY;
    it.query_index = INDEX_W'(idx);
    it.query_value = val;
    return it;
  endfunction

  function automatic sketch_item_t key_item(int chunk, logic [CHUNK_BITS-1:0] signs,
                                            logic [NORM_W-1:0] norm);
    sketch_item_t it;
    it             = random_fields();
    it.mode        = MODE_KEY;
    it.chunk_index = CHUNK_W'(chunk);
    it.sign_word   = signs;
    it.norm_bits   = norm;
    return it;
  endfunction

  // Near full scale, either sign.
  function automatic logic [QUERY_WIDTH-1:0] strong_value();
    int low;
    low = $urandom_range(0, 255);
    return $urandom_range(0, 1) ? QUERY_WIDTH'(16'h7FFF - low) : QUERY_WIDTH'(16'h8000 + low);
  endfunction

  // Signs that make every element of a chunk add its magnitude.
  function automatic logic [CHUNK_BITS-1:0] aligned_signs(int chunk);
    logic [CHUNK_BITS-1:0] w;
    for (int i = 0; i < CHUNK_BITS; i++)
      w[i] = ~scores.query_copy[chunk * CHUNK_BITS + i][QUERY_WIDTH-1];
    return w;
  endfunction

  function automatic logic [NORM_W-1:0] random_norm();
    int         pick;
    logic [7:0] ex;
    pick = $urandom_range(0, 99);
    if (pick < 80) ex = 8'($urandom_range(100, 150));
    else if (pick < 86) ex = EXP_ZERO;
    else if (pick < 92) ex = EXP_MAX;
    else ex = 8'($urandom);
    return {1'($urandom), ex, 7'($urandom)};
  endfunction

  // Present one item and hold it until the transfer; valid stays high on return.
  task automatic send_item(sketch_item_t it);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    if (!calm && $urandom_range(0, 99) < 3) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(5, 30)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= it.mode;
    in_ch.query_index <= it.query_index;
    in_ch.query_value <= it.query_value;
    in_ch.chunk_index <= it.chunk_index;
    in_ch.sign_word   <= it.sign_word;
    in_ch.norm_bits   <= it.norm_bits;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    scores.note_item(it);
  endtask

  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (scores.expected_scores.size() != 0) @(posedge clk);
    // let any trailing chunk finish before the next register write
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_scale(logic [SCALE_W-1:0] v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    scores.set_scale(v);
  endtask

  task automatic run_random(int target);
    int                    sent;
    int                    pick;
    logic [NORM_W-1:0]     norm;
    logic [CHUNK_BITS-1:0] signs;
    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        norm = random_norm();
        for (int c = 0; c <= LAST_CHUNK; c++) begin
          signs = {$urandom, $urandom};
          // some keys line up with the query to push the score toward saturation
          if (pick < 8)
            signs = aligned_signs(c) ^ (signs & {$urandom, $urandom} & {$urandom, $urandom});
          send_item(key_item(c, signs, norm));
        end
        sent += LAST_CHUNK + 1;
      end else if (pick < 90) begin
        send_item(query_item($urandom_range(0, PROJECTION_SIZE - 1), QUERY_WIDTH'($urandom)));
        sent++;
      end else begin
        send_item(key_item($urandom_range(0, LAST_CHUNK), {$urandom, $urandom}, random_norm()));
        sent++;
      end
    end
  endtask

  initial begin
    logic [CHUNK_BITS-1:0] match;
    logic [SCALE_W-1:0]    scale_plan[5];
    scores            = new();
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    calm              = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_QUERY;
    in_ch.query_index = '0;
    in_ch.query_value = '0;
    in_ch.chunk_index = '0;
    in_ch.sign_word   = '0;
    in_ch.norm_bits   = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Fill the whole store; the first chunk gets large magnitudes so repeats can wrap.
    for (int i = 0; i < PROJECTION_SIZE; i++)
      send_item(query_item(i, (i < CHUNK_BITS) ? strong_value() : QUERY_WIDTH'($urandom)));

    // Norm corners on a lone last chunk, reset scale.
    send_item(key_item(LAST_CHUNK, '1, 16'h3F80));
    send_item(key_item(LAST_CHUNK, '0, 16'hBF80));
    send_item(key_item(LAST_CHUNK, {$urandom, $urandom}, 16'h0000));
    send_item(key_item(LAST_CHUNK, {$urandom, $urandom}, 16'h8001));
    send_item(key_item(LAST_CHUNK, '1, 16'h7F80));
    send_item(key_item(LAST_CHUNK, '0, 16'hFFC1));
    send_item(key_item(LAST_CHUNK, '1, 16'h4B00));
    send_item(key_item(LAST_CHUNK, {$urandom, $urandom}, 16'h7F7F));
    send_item(key_item(LAST_CHUNK, '0, 16'h3000));
    send_item(key_item(LAST_CHUNK, '1, 16'h0080));
    send_item(query_item(PROJECTION_SIZE - 1, 16'h8000));
    send_item(query_item(0, 16'h7FFF));
    // out of order
    send_item(key_item(2, {$urandom, $urandom}, 16'h42F6));
    send_item(key_item(0, {$urandom, $urandom}, 16'h42F6));
    send_item(key_item(LAST_CHUNK, {$urandom, $urandom}, 16'h42F6));
    // repeat the first chunk until the accumulator wraps
    match = aligned_signs(0);
    repeat (9) send_item(key_item(0, match, 16'h3F80));
    send_item(key_item(LAST_CHUNK, aligned_signs(LAST_CHUNK), 16'h3F80));
    wait_quiet();

    scale_plan[0] = '1;
    scale_plan[1] = '0;
    scale_plan[2] = 16'd1;
    scale_plan[3] = SCALE_W'($urandom_range(2, 65534));
    scale_plan[4] = SCALE_W'($urandom_range(100, 2000));
    for (int p = 0; p < 5; p++) begin
      calm = (p == 3);
      write_scale(scale_plan[p]);
      run_random(PHASE_ITEMS);
      wait_quiet();
    end
    calm = 1'b0;

    if (scores.mismatches == 0 && scores.expected_scores.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
